[hw/rtl/gcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcw_pkg;

    // Width class codes
    localparam logic [2:0] CLS_NEUTRAL = 3'd0;
    localparam logic [2:0] CLS_AMBIG   = 3'd1;
    localparam logic [2:0] CLS_HALF    = 3'd2;
    localparam logic [2:0] CLS_WIDE    = 3'd3;
    localparam logic [2:0] CLS_FULL    = 3'd4;
    localparam logic [2:0] CLS_NARROW  = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_CONTEXT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIDGE_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAP_HIGH      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL_POINT = 3'd7;

    // Fixed width range table geometry
    localparam int ROM_SIZE    = 76;
    localparam int ROM_IDX_W   = 7;
    localparam int ROM_POINT_W = 18;

    typedef struct packed {
        logic        req_type;
        logic [63:0] code_point;
        logic        line_start;
        logic [3:0]  entry_index;
        logic [63:0] range_low;
        logic [63:0] range_high;
        logic [2:0]  entry_class;
    } gcw_in_t;

    typedef struct packed {
        logic [2:0]  width_class;
        logic [1:0]  cells;
        logic [31:0] column;
    } gcw_out_t;

    // One tailoring override entry as held in the store
    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
        logic [2:0]  cls;
    } ovr_entry_t;

    // Range table search status towards the top level
    typedef struct packed {
        logic       done;
        logic [2:0] cls;
    } rom_status_t;

    typedef struct packed {
        logic [ROM_POINT_W-1:0] first;
        logic [ROM_POINT_W-1:0] last;
        logic [2:0]             cls;
    } rom_range_t;

    // Sorted, non-overlapping width ranges
    function automatic rom_range_t rom_range(input logic [ROM_IDX_W-1:0] idx);
        rom_range_t r;
        case (idx)
            7'd0:  r = '{18'h000C5, 18'h000C5, CLS_NEUTRAL};
            7'd1:  r = '{18'h001D3, 18'h001D3, CLS_NEUTRAL};
            7'd2:  r = '{18'h001D4, 18'h001D4, CLS_AMBIG};
            7'd3:  r = '{18'h01100, 18'h0115F, CLS_WIDE};
            7'd4:  r = '{18'h020A9, 18'h020A9, CLS_HALF};
            7'd5:  r = '{18'h0212B, 18'h0212B, CLS_AMBIG};
            7'd6:  r = '{18'h02E80, 18'h02FDF, CLS_WIDE};
            7'd7:  r = '{18'h03000, 18'h0303E, CLS_WIDE};
            7'd8:  r = '{18'h03041, 18'h033FF, CLS_WIDE};
            7'd9:  r = '{18'h03400, 18'h04DBF, CLS_WIDE};
            7'd10: r = '{18'h04E00, 18'h09FFF, CLS_WIDE};
            7'd11: r = '{18'h0A000, 18'h0A4CF, CLS_WIDE};
            7'd12: r = '{18'h0A960, 18'h0A97F, CLS_WIDE};
            7'd13: r = '{18'h0AC00, 18'h0D7A3, CLS_WIDE};
            7'd14: r = '{18'h0D7B0, 18'h0D7FF, CLS_WIDE};
            7'd15: r = '{18'h0F900, 18'h0FAFF, CLS_WIDE};
            7'd16: r = '{18'h0FE10, 18'h0FE19, CLS_WIDE};
            7'd17: r = '{18'h0FE30, 18'h0FE52, CLS_WIDE};
            7'd18: r = '{18'h0FE54, 18'h0FE66, CLS_WIDE};
            7'd19: r = '{18'h0FE68, 18'h0FE6B, CLS_WIDE};
            7'd20: r = '{18'h0FF00, 18'h0FF00, CLS_FULL};
            7'd21: r = '{18'h0FF01, 18'h0FF5E, CLS_FULL};
            7'd22: r = '{18'h0FF61, 18'h0FF9F, CLS_HALF};
            7'd23: r = '{18'h0FFA0, 18'h0FFBE, CLS_HALF};
            7'd24: r = '{18'h0FFC2, 18'h0FFC7, CLS_HALF};
            7'd25: r = '{18'h0FFCA, 18'h0FFCF, CLS_HALF};
            7'd26: r = '{18'h0FFD2, 18'h0FFD7, CLS_HALF};
            7'd27: r = '{18'h0FFDA, 18'h0FFDC, CLS_HALF};
            7'd28: r = '{18'h0FFE0, 18'h0FFE6, CLS_FULL};
            7'd29: r = '{18'h0FFE8, 18'h0FFEE, CLS_HALF};
            7'd30: r = '{18'h16FE0, 18'h16FE4, CLS_WIDE};
            7'd31: r = '{18'h17000, 18'h187F7, CLS_WIDE};
            7'd32: r = '{18'h18800, 18'h18CD5, CLS_WIDE};
            7'd33: r = '{18'h1B000, 18'h1B2FB, CLS_WIDE};
            7'd34: r = '{18'h1F004, 18'h1F004, CLS_WIDE};
            7'd35: r = '{18'h1F0CF, 18'h1F0CF, CLS_WIDE};
            7'd36: r = '{18'h1F18E, 18'h1F18E, CLS_WIDE};
            7'd37: r = '{18'h1F191, 18'h1F19A, CLS_WIDE};
            7'd38: r = '{18'h1F200, 18'h1F202, CLS_WIDE};
            7'd39: r = '{18'h1F210, 18'h1F23B, CLS_WIDE};
            7'd40: r = '{18'h1F240, 18'h1F248, CLS_WIDE};
            7'd41: r = '{18'h1F250, 18'h1F251, CLS_WIDE};
            7'd42: r = '{18'h1F260, 18'h1F265, CLS_WIDE};
            7'd43: r = '{18'h1F300, 18'h1F320, CLS_WIDE};
            7'd44: r = '{18'h1F32D, 18'h1F335, CLS_WIDE};
            7'd45: r = '{18'h1F337, 18'h1F37C, CLS_WIDE};
            7'd46: r = '{18'h1F37E, 18'h1F393, CLS_WIDE};
            7'd47: r = '{18'h1F3A0, 18'h1F3CA, CLS_WIDE};
            7'd48: r = '{18'h1F3CF, 18'h1F3D3, CLS_WIDE};
            7'd49: r = '{18'h1F3E0, 18'h1F3F0, CLS_WIDE};
            7'd50: r = '{18'h1F3F4, 18'h1F3F4, CLS_WIDE};
            7'd51: r = '{18'h1F3F8, 18'h1F43E, CLS_WIDE};
            7'd52: r = '{18'h1F440, 18'h1F440, CLS_WIDE};
            7'd53: r = '{18'h1F442, 18'h1F4FC, CLS_WIDE};
            7'd54: r = '{18'h1F4FF, 18'h1F53D, CLS_WIDE};
            7'd55: r = '{18'h1F54B, 18'h1F54E, CLS_WIDE};
            7'd56: r = '{18'h1F550, 18'h1F567, CLS_WIDE};
            7'd57: r = '{18'h1F57A, 18'h1F57A, CLS_WIDE};
            7'd58: r = '{18'h1F595, 18'h1F596, CLS_WIDE};
            7'd59: r = '{18'h1F5A4, 18'h1F5A4, CLS_WIDE};
            7'd60: r = '{18'h1F5FB, 18'h1F64F, CLS_WIDE};
            7'd61: r = '{18'h1F680, 18'h1F6C5, CLS_WIDE};
            7'd62: r = '{18'h1F6CC, 18'h1F6CC, CLS_WIDE};
            7'd63: r = '{18'h1F6D0, 18'h1F6D2, CLS_WIDE};
            7'd64: r = '{18'h1F6D5, 18'h1F6D7, CLS_WIDE};
            7'd65: r = '{18'h1F6DC, 18'h1F6DF, CLS_WIDE};
            7'd66: r = '{18'h1F6EB, 18'h1F6EC, CLS_WIDE};
            7'd67: r = '{18'h1F6F4, 18'h1F6FC, CLS_WIDE};
            7'd68: r = '{18'h1F7E0, 18'h1F7EB, CLS_WIDE};
            7'd69: r = '{18'h1F7F0, 18'h1F7F0, CLS_WIDE};
            7'd70: r = '{18'h1F90C, 18'h1F93A, CLS_WIDE};
            7'd71: r = '{18'h1F93C, 18'h1F945, CLS_WIDE};
            7'd72: r = '{18'h1F947, 18'h1F9FF, CLS_WIDE};
            7'd73: r = '{18'h1FA70, 18'h1FAFF, CLS_WIDE};
            7'd74: r = '{18'h20000, 18'h2FFFD, CLS_WIDE};
            7'd75: r = '{18'h30000, 18'h3FFFD, CLS_WIDE};
            // empty range: never matches
            default: r = '{18'h00001, 18'h00000, CLS_NARROW};
        endcase
        return r;
    endfunction

    // Grid cells taken by a class
    function automatic logic [1:0] cells_of(input logic [2:0] cls, input logic wide_ctx);
        logic [1:0] c;
        if ((cls == CLS_WIDE) || (cls == CLS_FULL) || ((cls == CLS_AMBIG) && wide_ctx)) begin
            c = 2'd2;
        end else begin
            c = 2'd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/gcw_ovr_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcw_ovr_store #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [IDX_W-1:0]    wr_addr,
    input  wire gcw_pkg::ovr_entry_t wr_entry,
    input  wire logic                rd_en,
    input  wire logic [IDX_W-1:0]    rd_addr,
    output gcw_pkg::ovr_entry_t      rd_entry
);
    import gcw_pkg::*;

    // Override table, one write and one registered read per cycle
    ovr_entry_t ovr_mem [DEPTH];
    ovr_entry_t rd_entry_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ovr_mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= ovr_mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

[hw/rtl/gcw_rom_search.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcw_rom_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] start_cp,
    output gcw_pkg::rom_status_t status
);
    import gcw_pkg::*;

    logic [ROM_IDX_W-1:0]   lo_reg;
    logic [ROM_IDX_W-1:0]   hi_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [2:0]             cls_reg;
    logic [ROM_POINT_W-1:0] cp_reg;
    logic                   cp_big_reg;

    logic [ROM_IDX_W-1:0]   mid;
    logic [ROM_IDX_W-1:0]   lo_next;
    logic [ROM_IDX_W-1:0]   hi_next;
    rom_range_t             probe;
    logic                   below;
    logic                   above;

    // One probe of the range table per cycle
    always_comb begin
        mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
        probe = rom_range(mid);
        below = !cp_big_reg && (cp_reg < probe.first);
        above = cp_big_reg || (cp_reg > probe.last);
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (below) begin
            hi_next = mid;
        end else if (above) begin
            lo_next = mid + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if ((!below && !above) || (lo_next >= hi_next)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Search window and result
    always_ff @(posedge aclk) begin
        if (start) begin
            lo_reg     <= '0;
            hi_reg     <= ROM_IDX_W'(ROM_SIZE);
            cp_reg     <= start_cp[ROM_POINT_W-1:0];
            cp_big_reg <= (start_cp[63:ROM_POINT_W] != '0);
        end else if (busy_reg) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            if (!below && !above) begin
                cls_reg <= probe.cls;
            end else if (lo_next >= hi_next) begin
                cls_reg <= CLS_NARROW;
            end
        end
    end

    assign status.done = done_reg;
    assign status.cls  = cls_reg;

endmodule

`default_nettype wire

[hw/rtl/glyph_cell_width_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none

// Glyph cell width classifier.
// Input beats (s_*) carry either a code point to classify (req_type 0) or a
// tailoring override entry to store (req_type 1). Each classify beat yields
// one result beat (m_*) with the width class, the cells taken and the running
// column; a store beat yields none and leaves the column alone.
// Overrides are found by binary search in a store with one write port and
// one registered read port, one probe per cycle; the fixed range table is
// searched in parallel, one probe per cycle, at most 7 probes. A classify
// beat reaches the result register once both searches are done and the
// result register is free; the next beat is taken only after that, once the
// block is back in idle. A store beat is written without leaving idle.
// s_ready is high only in the idle state, also while a result waits.
// If m_ready stays low, a finished item waits in its last state until the
// result register frees, and no further beat is taken.
// Reset (aresetn low, synchronous) clears the column, the configuration
// registers and the handshake state; override entries are undefined until
// written. The user must write configuration through cfg_we/cfg_index/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module glyph_cell_width_classifier #(
    parameter int OVERRIDE_DEPTH = 16,
    parameter int COLUMN_BITS    = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [gcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [63:0]                       cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire gcw_pkg::gcw_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output gcw_pkg::gcw_out_t                      m_data
);
    import gcw_pkg::*;

    localparam int IDX_W = (OVERRIDE_DEPTH > 1) ? $clog2(OVERRIDE_DEPTH) : 1;
    localparam int CNT_W = $clog2(OVERRIDE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PROBE  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Configuration registers
    logic        wide_ctx_reg;
    logic [4:0]  ovr_count_reg;
    logic [63:0] bridge_max_reg;
    logic [63:0] ctrl_lo_reg;
    logic [63:0] ctrl_hi_reg;
    logic [63:0] trap_lo_reg;
    logic [63:0] trap_hi_reg;
    logic [63:0] sentinel_reg;

    // Item and search state
    logic [1:0]             state_reg, state_next;
    logic [63:0]            cp_reg;
    logic                   line_start_reg;
    logic                   zero_cell_reg;
    logic                   in_bridge_reg;
    logic [CNT_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]       hi_reg, hi_next;
    logic [CNT_W-1:0]       mid_reg, mid_next;
    logic                   hit_reg, hit_next;
    logic [2:0]             hit_cls_reg, hit_cls_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   m_valid_reg;
    gcw_out_t               m_data_reg;

    // Store ports
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    ovr_entry_t             wr_entry;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    ovr_entry_t             rd_entry;
    rom_status_t            rom_st;

    // Combinational helpers
    logic                   accept;
    logic                   idx_ok;
    logic [CNT_W-1:0]       cnt_sat;
    logic [CNT_W-1:0]       mid0;
    logic [CNT_W-1:0]       nlo, nhi, nmid;
    logic                   below, above;
    logic [2:0]             fin_cls;
    logic [1:0]             fin_cells;
    logic [COLUMN_BITS-1:0] col_base;
    logic [COLUMN_BITS:0]   col_sum;
    logic                   load_out;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign idx_ok  = (32'(s_data.entry_index) < OVERRIDE_DEPTH);
    assign cnt_sat = (32'(ovr_count_reg) > OVERRIDE_DEPTH) ? CNT_W'(OVERRIDE_DEPTH)
                                                          : CNT_W'(ovr_count_reg);
    assign mid0    = cnt_sat >> 1;

    // Override entry write path; classes six and seven fold to neutral
    assign wr_addr        = IDX_W'(s_data.entry_index);
    assign wr_entry.low   = s_data.range_low;
    assign wr_entry.high  = s_data.range_high;
    assign wr_entry.cls   = (s_data.entry_class > CLS_NARROW) ? CLS_NEUTRAL : s_data.entry_class;

    gcw_ovr_store #(
        .DEPTH(OVERRIDE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_entry(wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_entry(rd_entry)
    );

    gcw_rom_search u_rom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && !s_data.req_type),
        .start_cp(s_data.code_point),
        .status  (rom_st)
    );

    // Result of the item and running column
    always_comb begin
        fin_cls   = hit_reg ? hit_cls_reg : (in_bridge_reg ? rom_st.cls : CLS_NEUTRAL);
        fin_cells = (!hit_reg && zero_cell_reg) ? 2'd0 : cells_of(fin_cls, wide_ctx_reg);
        col_base  = line_start_reg ? '0 : col_reg;
        col_sum   = {1'b0, col_base} + (COLUMN_BITS + 1)'(fin_cells);
    end

    // Override search sequencer
    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        hit_next     = hit_reg;
        hit_cls_next = hit_cls_reg;
        col_next     = col_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = mid_reg[IDX_W-1:0];
        load_out     = 1'b0;
        below        = (cp_reg < rd_entry.low);
        above        = (cp_reg > rd_entry.high);
        nlo          = lo_reg;
        nhi          = hi_reg;
        if (below) begin
            nhi = mid_reg;
        end else if (above) begin
            nlo = mid_reg + 1'b1;
        end
        nmid = nlo + ((nhi - nlo) >> 1);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.req_type) begin
                        wr_en = idx_ok;
                    end else begin
                        lo_next  = '0;
                        hi_next  = cnt_sat;
                        hit_next = 1'b0;
                        if (cnt_sat != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = mid0[IDX_W-1:0];
                            mid_next   = mid0;
                            state_next = ST_PROBE;
                        end else begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_PROBE: begin
                if (!below && !above) begin
                    hit_next     = 1'b1;
                    hit_cls_next = rd_entry.cls;
                    state_next   = ST_FINISH;
                end else begin
                    lo_next = nlo;
                    hi_next = nhi;
                    if (nlo < nhi) begin
                        rd_en    = 1'b1;
                        rd_addr  = nmid[IDX_W-1:0];
                        mid_next = nmid;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (rom_st.done && (!m_valid_reg || m_ready)) begin
                    load_out   = 1'b1;
                    col_next   = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_ctx_reg   <= 1'b0;
            ovr_count_reg  <= '0;
            bridge_max_reg <= 64'h10FFFF;
            ctrl_lo_reg    <= 64'd1;
            ctrl_hi_reg    <= 64'd0;
            trap_lo_reg    <= 64'd1;
            trap_hi_reg    <= 64'd0;
            sentinel_reg   <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDE_CONTEXT:   wide_ctx_reg   <= cfg_wdata[0];
                CFG_OVERRIDE_COUNT: ovr_count_reg  <= cfg_wdata[4:0];
                CFG_BRIDGE_MAX:     bridge_max_reg <= cfg_wdata;
                CFG_CONTROL_LOW:    ctrl_lo_reg    <= cfg_wdata;
                CFG_CONTROL_HIGH:   ctrl_hi_reg    <= cfg_wdata;
                CFG_TRAP_LOW:       trap_lo_reg    <= cfg_wdata;
                CFG_TRAP_HIGH:      trap_hi_reg    <= cfg_wdata;
                CFG_SENTINEL_POINT: sentinel_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item payload and search window; zero-cell and bridge checks taken on entry
    always_ff @(posedge aclk) begin
        if (accept && !s_data.req_type) begin
            cp_reg         <= s_data.code_point;
            line_start_reg <= s_data.line_start;
            in_bridge_reg  <= (s_data.code_point <= bridge_max_reg);
            zero_cell_reg  <= ((s_data.code_point >= ctrl_lo_reg) &&
                               (s_data.code_point <= ctrl_hi_reg)) ||
                              ((s_data.code_point >= trap_lo_reg) &&
                               (s_data.code_point <= trap_hi_reg)) ||
                              (s_data.code_point == sentinel_reg);
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        hit_reg     <= hit_next;
        hit_cls_reg <= hit_cls_next;
        if (load_out) begin
            m_data_reg.width_class <= fin_cls;
            m_data_reg.cells       <= fin_cells;
            m_data_reg.column      <= 32'(col_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Every override probe lies inside a non-empty window
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> ((lo_reg <= mid_reg) && (mid_reg < hi_reg)))
        else $error("override probe outside search window");

    // A result only appears from the finishing state
    a_load_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result loaded outside finishing state");

    // Result codes stay in range
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.cells != 2'd3) && (m_data_reg.width_class <= CLS_NARROW)))
        else $error("result code out of range");

    // A store beat finishes at once and gives no result
    a_store_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.req_type) |=>
            ((state_reg == ST_IDLE) && !$rose(m_valid_reg)))
        else $error("store beat produced work or a result");
`endif

endmodule

`default_nettype wire
